// ===== rtl/rlpe_pkg.sv =====
package rlpe_pkg;

   // Length field bytes and the short-string limit of the encoding.
   localparam int LENGTH_BYTES = 4;
   localparam int SHORT_LIMIT  = 55;

   // Prefix codes of the encoding.
   localparam logic [7:0] EMPTY_CODE = 8'h80;
   localparam logic [7:0] SINGLE_MAX = 8'h7f;
   localparam logic [7:0] SHORT_BASE = 8'h80;
   localparam logic [7:0] LONG_BASE  = 8'hb7;

   // Largest length that LENGTH_BYTES bytes can carry, limited to the 32-bit field.
   localparam logic [63:0] LEN_LIM_WIDE = (64'd1 << (8 * LENGTH_BYTES)) - 64'd1;
   localparam logic [31:0] LEN_MAX      = (LENGTH_BYTES >= 4) ? 32'hffff_ffff
                                                              : LEN_LIM_WIDE[31:0];

   // Entries of the queue between the front and back ends.
   localparam int QUEUE_DEPTH = 2;

   // One classified transaction: an optional header byte, up to four length
   // bytes taken from len, and a closing byte.
   typedef struct packed {
      logic        has_head;
      logic [7:0]  head_byte;
      logic [2:0]  num_len;
      logic [31:0] len;
      logic [7:0]  tail_byte;
      logic        err;
      logic        ends;
   } desc_type;

endpackage

// ===== rtl/rlpe_req_if.sv =====
interface rlpe_req_if;
   logic        valid;
   logic        ready;
   logic        start_req;
   logic [31:0] string_length;
   logic [7:0]  data_byte;

   modport source (output valid, output start_req, output string_length,
                   output data_byte, input ready);
   modport sink   (input valid, input start_req, input string_length,
                   input data_byte, output ready);
endinterface

// ===== rtl/rlpe_rsp_if.sv =====
interface rlpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       encoding_end;
   logic       sequence_error;

   modport source (output valid, output out_byte, output run_last,
                   output encoding_end, output sequence_error, input ready);
   modport sink   (input valid, input out_byte, input run_last,
                   input encoding_end, input sequence_error, output ready);
endinterface

// ===== rtl/rlp_string_encoder.sv =====
// Recursive length prefix encoder for byte strings. The first transaction of a
// string carries its length and first byte; each further transaction carries one
// payload byte. Results leave one byte per cycle through a registered output
// while the receiver is ready. Payload transactions sustain one per cycle while
// the queue has room and the output is not held. The first transaction of a string
// produces one to six result bytes (header, up to four length bytes, first payload
// byte) and holds the result side until they are all out; the two-entry queue
// between the classifying front end and the byte-emitting back end takes one more
// transaction meanwhile, after which the input stalls until the queue has room.
module rlp_string_encoder #(
   parameter int LENGTH_BYTES = rlpe_pkg::LENGTH_BYTES,
   parameter int SHORT_LIMIT  = rlpe_pkg::SHORT_LIMIT
) (
   input  logic       clock,
   input  logic       reset,
   rlpe_req_if.sink   req_ch,
   rlpe_rsp_if.source rsp_ch
);
   import rlpe_pkg::*;

   logic     q_push, q_full, q_pop, q_valid;
   desc_type q_in_data, q_head_data;

   // Classify incoming transactions and track the remaining payload count.
   rlpe_front #(
      .LENGTH_BYTES (LENGTH_BYTES),
      .SHORT_LIMIT  (SHORT_LIMIT)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_in_data)
   );

   // Decouple the front end from the byte emitter.
   rlpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_in_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head_data)
   );

   // Emit the encoded bytes one per cycle while the output is ready.
   rlpe_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_head_data),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ===== rtl/rlpe_front.sv =====
module rlpe_front #(
   parameter int LENGTH_BYTES = rlpe_pkg::LENGTH_BYTES,
   parameter int SHORT_LIMIT  = rlpe_pkg::SHORT_LIMIT
) (
   input  logic              clock,
   input  logic              reset,
   rlpe_req_if.sink          req_ch,
   input  logic              q_full,
   output logic              q_push,
   output rlpe_pkg::desc_type q_data
);
   import rlpe_pkg::*;

   // Largest length that LENGTH_BYTES bytes can carry, limited to the 32-bit field.
   localparam logic [63:0] LenLimWide = (64'd1 << (8 * LENGTH_BYTES)) - 64'd1;
   localparam logic [31:0] LenMax     = (LENGTH_BYTES >= 4) ? 32'hffff_ffff
                                                            : LenLimWide[31:0];

   logic [31:0] remain_ff, remain_in;
   logic [31:0] len_sat;
   logic [2:0]  num_bytes;
   logic        accept;

   // A transaction is taken whenever the queue has room.
   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;
   assign q_push       = accept;

   // Saturate the length and count its significant bytes.
   always_comb begin
      len_sat = (req_ch.string_length > LenMax) ? LenMax : req_ch.string_length;
      if (len_sat[31:24] != 8'd0) begin
         num_bytes = 3'd4;
      end else if (len_sat[23:16] != 8'd0) begin
         num_bytes = 3'd3;
      end else if (len_sat[15:8] != 8'd0) begin
         num_bytes = 3'd2;
      end else begin
         num_bytes = 3'd1;
      end
   end

   // Classify the transaction and work out the payload count left after it.
   always_comb begin
      q_data           = '0;
      q_data.len       = len_sat;
      q_data.tail_byte = req_ch.data_byte;
      remain_in        = remain_ff;
      if (req_ch.start_req) begin
         q_data.err = (remain_ff != 32'd0);
         if (len_sat == 32'd0) begin
            q_data.tail_byte = EMPTY_CODE;
            q_data.ends      = 1'b1;
            remain_in        = 32'd0;
         end else if (len_sat == 32'd1 && req_ch.data_byte <= SINGLE_MAX) begin
            q_data.ends = 1'b1;
            remain_in   = 32'd0;
         end else begin
            q_data.has_head = 1'b1;
            if (len_sat <= 32'(SHORT_LIMIT)) begin
               q_data.head_byte = SHORT_BASE + len_sat[7:0];
               q_data.num_len   = 3'd0;
            end else begin
               q_data.head_byte = LONG_BASE + {5'd0, num_bytes};
               q_data.num_len   = num_bytes;
            end
            remain_in   = len_sat - 32'd1;
            q_data.ends = (len_sat == 32'd1);
         end
      end else if (remain_ff == 32'd0) begin
         q_data.tail_byte = 8'd0;
         q_data.err       = 1'b1;
      end else begin
         remain_in   = remain_ff - 32'd1;
         q_data.ends = (remain_ff == 32'd1);
      end
   end

   // Payload bytes still expected in the current string.
   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= 32'd0;
      end else if (accept) begin
         remain_ff <= remain_in;
      end
   end

endmodule

// ===== rtl/rlpe_queue.sv =====
module rlpe_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rlpe_pkg::desc_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output rlpe_pkg::desc_type head_data
);
   import rlpe_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

   desc_type        entries_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == CntW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entries_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/rlpe_back.sv =====
module rlpe_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  rlpe_pkg::desc_type q_data,
   output logic               q_pop,
   rlpe_rsp_if.source         rsp_ch
);
   import rlpe_pkg::*;

   logic [2:0] ph_ff, ph_in;
   logic [2:0] idx;
   logic [1:0] sel;
   logic       at_head, at_tail, load;
   logic [7:0] len_byte, byte_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff, end_ff, err_ff;

   // The output register takes a new byte when a transaction waits and it is empty or being drained.
   assign load  = q_valid && (!valid_ff || rsp_ch.ready);
   assign q_pop = load && at_tail;

   // Pick the byte of the head transaction that the phase points at.
   always_comb begin
      idx     = ph_ff - {2'd0, q_data.has_head};
      at_head = q_data.has_head && (ph_ff == 3'd0);
      at_tail = !at_head && (idx == q_data.num_len);
      sel     = q_data.num_len[1:0] - 2'd1 - idx[1:0];
      case (sel)
         2'd0:    len_byte = q_data.len[7:0];
         2'd1:    len_byte = q_data.len[15:8];
         2'd2:    len_byte = q_data.len[23:16];
         2'd3:    len_byte = q_data.len[31:24];
         default: len_byte = q_data.len[7:0];
      endcase
      if (at_head) begin
         byte_in = q_data.head_byte;
      end else if (at_tail) begin
         byte_in = q_data.tail_byte;
      end else begin
         byte_in = len_byte;
      end
   end

   // Phase within the head transaction and output valid.
   always_comb begin
      ph_in    = ph_ff;
      valid_in = valid_ff;
      if (load) begin
         ph_in    = at_tail ? 3'd0 : ph_ff + 3'd1;
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff    <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         ph_ff    <= ph_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= at_tail;
         end_ff  <= at_tail && q_data.ends;
         err_ff  <= q_data.err;
      end
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.out_byte       = byte_ff;
   assign rsp_ch.run_last       = last_ff;
   assign rsp_ch.encoding_end   = end_ff;
   assign rsp_ch.sequence_error = err_ff;

endmodule
